>>> rtl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, masked during reset.
`define KEDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication into the next cycle, masked during reset.
`define KEDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication into the next cycle, checked during reset as well.
`define KEDC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/kedc_pkg.sv
// Package: key codes, decode phases, register indexes and shared types.
package kedc_pkg;

  localparam logic [8:0] KEY_ESC   = 9'd27;
  localparam logic [8:0] KEY_QUIT  = 9'd17;
  localparam logic [8:0] KEY_LEFT  = 9'd256;
  localparam logic [8:0] KEY_RIGHT = 9'd257;
  localparam logic [8:0] KEY_UP    = 9'd258;
  localparam logic [8:0] KEY_DOWN  = 9'd259;
  localparam logic [8:0] KEY_PGUP  = 9'd260;
  localparam logic [8:0] KEY_PGDN  = 9'd261;
  localparam logic [8:0] KEY_HOME  = 9'd262;
  localparam logic [8:0] KEY_END   = 9'd263;
  localparam logic [8:0] KEY_DEL   = 9'd264;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_LBR   = 8'h5B;
  localparam logic [7:0] BYTE_O     = 8'h4F;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_0     = 8'h30;
  localparam logic [7:0] BYTE_9     = 8'h39;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_SEQ0  = 2'd2;
  localparam logic [1:0] PH_DIGIT = 2'd3;

  localparam logic [1:0] REG_SCREEN_ROWS = 2'd0;
  localparam logic [1:0] REG_SCREEN_COLS = 2'd1;
  localparam logic [1:0] REG_LINE_COUNT  = 2'd2;

  localparam logic [9:0]  RESET_SCREEN_ROWS = 10'd24;
  localparam logic [9:0]  RESET_SCREEN_COLS = 10'd80;
  localparam logic [15:0] RESET_LINE_COUNT  = 16'd0;

  typedef struct packed {
    logic       has_key;
    logic [8:0] key;
    logic [1:0] phase_next;
    logic [7:0] first_next;
    logic [7:0] digit_next;
  } dec_out_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [15:0] row;
    logic [15:0] off;
  } pos_t;

  function automatic logic [8:0] decode_letter(input logic [7:0] lead, input logic [7:0] b);
    logic [8:0] k;
    k = KEY_ESC;
    if (lead == BYTE_LBR) begin
      case (b)
        8'h41:   k = KEY_UP;
        8'h42:   k = KEY_DOWN;
        8'h43:   k = KEY_RIGHT;
        8'h44:   k = KEY_LEFT;
        8'h48:   k = KEY_HOME;
        8'h46:   k = KEY_END;
        default: k = KEY_ESC;
      endcase
    end else if (lead == BYTE_O) begin
      case (b)
        8'h48:   k = KEY_HOME;
        8'h46:   k = KEY_END;
        default: k = KEY_ESC;
      endcase
    end
    return k;
  endfunction

  function automatic logic [8:0] decode_tilde(input logic [7:0] d);
    logic [8:0] k;
    case (d)
      8'h31, 8'h37: k = KEY_HOME;
      8'h33:        k = KEY_DEL;
      8'h34, 8'h38: k = KEY_END;
      8'h35:        k = KEY_PGUP;
      8'h36:        k = KEY_PGDN;
      default:      k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/kedc_decode.sv
// Escape sequence decoder: next phase and decoded key for one input item.
module kedc_decode (
  input  logic               operation,
  input  logic [7:0]         in_byte,
  input  logic [1:0]         phase,
  input  logic [7:0]         first_byte,
  input  logic [7:0]         digit_byte,
  output kedc_pkg::dec_out_t dec
);
  import kedc_pkg::*;

  always_comb begin
    dec.has_key    = 1'b0;
    dec.key        = KEY_ESC;
    dec.phase_next = phase;
    dec.first_next = first_byte;
    dec.digit_next = digit_byte;
    if (operation == OP_TIMEOUT) begin
      if (phase != PH_IDLE) begin
        dec.phase_next = PH_IDLE;
        dec.has_key    = 1'b1;
      end
    end else begin
      case (phase)
        PH_ESC: begin
          dec.first_next = in_byte;
          dec.phase_next = PH_SEQ0;
        end
        PH_SEQ0: begin
          if (first_byte == BYTE_LBR && in_byte >= BYTE_0 && in_byte <= BYTE_9) begin
            dec.digit_next = in_byte;
            dec.phase_next = PH_DIGIT;
          end else begin
            dec.phase_next = PH_IDLE;
            dec.has_key    = 1'b1;
            dec.key        = decode_letter(first_byte, in_byte);
          end
        end
        PH_DIGIT: begin
          dec.phase_next = PH_IDLE;
          dec.has_key    = 1'b1;
          dec.key        = (in_byte == BYTE_TILDE) ? decode_tilde(digit_byte) : KEY_ESC;
        end
        default: begin
          if (in_byte == BYTE_ESC) begin
            dec.phase_next = PH_ESC;
          end else begin
            dec.phase_next = PH_IDLE;
            dec.has_key    = 1'b1;
            dec.key        = {1'b0, in_byte};
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/kedc_cursor.sv
// Cursor motion and view scroll for one decoded key.
module kedc_cursor (
  input  logic [8:0]     key,
  input  kedc_pkg::pos_t pos,
  input  logic [9:0]     screen_rows,
  input  logic [9:0]     screen_cols,
  input  logic [15:0]    line_count,
  output kedc_pkg::pos_t pos_next
);
  import kedc_pkg::*;

  logic [9:0]  col_m;
  logic [15:0] row_m;
  logic [16:0] pg_sum;
  logic [9:0]  height;
  logic [15:0] off_a;
  logic [16:0] view_end;

  assign pg_sum = {1'b0, pos.row} + {7'd0, screen_rows};

  always_comb begin
    col_m = pos.col;
    row_m = pos.row;
    case (key)
      KEY_LEFT: begin
        if (pos.col != 10'd0) col_m = pos.col - 10'd1;
      end
      KEY_RIGHT: begin
        if (({1'b0, pos.col} + 11'd1) < {1'b0, screen_cols}) col_m = pos.col + 10'd1;
      end
      KEY_UP: begin
        if (pos.row != 16'd0) row_m = pos.row - 16'd1;
      end
      KEY_DOWN: begin
        if (pos.row < line_count) row_m = pos.row + 16'd1;
      end
      KEY_HOME: begin
        col_m = 10'd0;
      end
      KEY_END: begin
        col_m = (screen_cols == 10'd0) ? 10'd0 : screen_cols - 10'd1;
      end
      KEY_PGUP: begin
        row_m = (pos.row >= {6'd0, screen_rows}) ? pos.row - {6'd0, screen_rows} : 16'd0;
      end
      KEY_PGDN: begin
        if (pos.row < line_count) begin
          row_m = (pg_sum > {1'b0, line_count}) ? line_count : pg_sum[15:0];
        end
      end
      default: begin
        col_m = pos.col;
      end
    endcase
  end

  assign height   = (screen_rows == 10'd0) ? 10'd1 : screen_rows;
  assign off_a    = (row_m < pos.off) ? row_m : pos.off;
  assign view_end = {1'b0, off_a} + {7'd0, height};

  assign pos_next.col = col_m;
  assign pos_next.row = row_m;
  assign pos_next.off = ({1'b0, row_m} >= view_end) ? row_m - {6'd0, height} + 16'd1 : off_a;

endmodule

>>> rtl/key_escape_decode_and_cursor.sv
// Top level: terminal key escape decoder driving a cursor and view offset.
//
// Input channel (item_valid/item_stall): one transfer per terminal byte or
// read timeout (operation high). Each transfer lands in an input register;
// from there it is decoded and applied to the cursor, and any result is
// written to the result register. Bytes that only extend an escape sequence,
// and timeouts while no sequence is pending, produce no result.
// Output channel (result_valid/result_stall): key code, cursor column and
// row, view offset and quit. One item per cycle is sustained while the
// receiver does not stall; the single decode and cursor pass between input
// and result register sets that figure.
// While the receiver stalls, the result is held and one further item waits in
// the input register; item_stall rises only when both are occupied.
// After a quit result every further item is taken and dropped until reset.
// Configuration (cfg_valid/cfg_ready): always ready; write only while idle.
// Reset clears the pipeline, cursor, view, decode phase and quit latch, and
// restores the screen size to 24 by 80 with no lines loaded.
module key_escape_decode_and_cursor (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        operation,
  input  logic [7:0]  in_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [8:0]  key_code,
  output logic [9:0]  cursor_col,
  output logic [15:0] cursor_row,
  output logic [15:0] view_offset,
  output logic        quit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kedc_pkg::*;

  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;

  logic [1:0]  phase;
  logic [7:0]  first_byte;
  logic [7:0]  digit_byte;
  pos_t        pos;
  logic        halted;
  logic [9:0]  screen_rows;
  logic [9:0]  screen_cols;
  logic [15:0] line_count;

  dec_out_t dec;
  pos_t     pos_next;
  logic     proc;
  logic     accept;
  logic     emit;
  logic     is_quit;

  assign cfg_ready  = 1'b1;
  assign proc       = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !proc;
  assign accept     = item_valid && !item_stall;
  assign emit       = proc && !halted && dec.has_key;
  assign is_quit    = (dec.key == KEY_QUIT);

  kedc_decode u_decode (
    .operation  (s1_op),
    .in_byte    (s1_byte),
    .phase      (phase),
    .first_byte (first_byte),
    .digit_byte (digit_byte),
    .dec        (dec)
  );

  kedc_cursor u_cursor (
    .key         (dec.key),
    .pos         (pos),
    .screen_rows (screen_rows),
    .screen_cols (screen_cols),
    .line_count  (line_count),
    .pos_next    (pos_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      phase        <= PH_IDLE;
      first_byte   <= 8'd0;
      digit_byte   <= 8'd0;
      pos          <= '0;
      halted       <= 1'b0;
      screen_rows  <= RESET_SCREEN_ROWS;
      screen_cols  <= RESET_SCREEN_COLS;
      line_count   <= RESET_LINE_COUNT;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (proc) begin
        s1_valid <= 1'b0;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (proc && !halted) begin
        phase      <= dec.phase_next;
        first_byte <= dec.first_next;
        digit_byte <= dec.digit_next;
        if (dec.has_key) begin
          if (is_quit) begin
            halted <= 1'b1;
          end else begin
            pos <= pos_next;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_ROWS: screen_rows <= cfg_data[9:0];
          REG_SCREEN_COLS: screen_cols <= cfg_data[9:0];
          REG_LINE_COUNT:  line_count  <= cfg_data;
          default:         line_count  <= line_count;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= operation;
      s1_byte <= in_byte;
    end
    if (emit) begin
      key_code <= dec.key;
      quit     <= is_quit;
      if (is_quit) begin
        cursor_col  <= pos.col;
        cursor_row  <= pos.row;
        view_offset <= pos.off;
      end else begin
        cursor_col  <= pos_next.col;
        cursor_row  <= pos_next.row;
        view_offset <= pos_next.off;
      end
    end
  end

endmodule

>>> rtl/kedc_checker.sv
// Port checker for the key decoder, bound to the top level.
`include "assert_macros.svh"

module kedc_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [8:0]  key_code,
  input logic [9:0]  cursor_col,
  input logic [15:0] cursor_row,
  input logic [15:0] view_offset,
  input logic        quit
);
  import kedc_pkg::*;

  logic [51:0] payload;

  assign payload = {key_code, cursor_col, cursor_row, view_offset, quit};

  `KEDC_ASSERT_NEXT_ALWAYS(a_reset_clears, rst, !result_valid)
  `KEDC_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(payload))
  `KEDC_ASSERT_NEXT(a_quit_final, result_valid && quit && !result_stall, !result_valid)
  `KEDC_ASSERT_NOW(a_quit_key, result_valid && quit, key_code == KEY_QUIT)
  `KEDC_ASSERT_NOW(a_key_range, result_valid, key_code <= KEY_DEL)

endmodule

bind key_escape_decode_and_cursor kedc_checker u_kedc_checker (.*);

>>> tb/key_decode_checker.sv
// Key decoder checker: predicts each decoded key and cursor update and compares results.
package kedc_tb_pkg;

  localparam logic [7:0] CH_UP    = "A";
  localparam logic [7:0] CH_DOWN  = "B";
  localparam logic [7:0] CH_RIGHT = "C";
  localparam logic [7:0] CH_LEFT  = "D";
  localparam logic [7:0] CH_HOME  = "H";
  localparam logic [7:0] CH_END   = "F";

  localparam logic [7:0] DIGIT_HOME     = "1";
  localparam logic [7:0] DIGIT_DEL      = "3";
  localparam logic [7:0] DIGIT_END      = "4";
  localparam logic [7:0] DIGIT_PGUP     = "5";
  localparam logic [7:0] DIGIT_PGDN     = "6";
  localparam logic [7:0] DIGIT_HOME_ALT = "7";
  localparam logic [7:0] DIGIT_END_ALT  = "8";

  localparam logic [7:0] BYTE_CTRL_Q = 8'h11;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  typedef struct packed {
    logic [8:0]  key;
    logic [9:0]  col;
    logic [15:0] row;
    logic [15:0] off;
    logic        quit;
  } key_result_t;

endpackage

module key_decode_checker
  import kedc_pkg::*;
  import kedc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        operation,
  input  logic [7:0]  in_byte,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [8:0]  key_code,
  input  logic [9:0]  cursor_col,
  input  logic [15:0] cursor_row,
  input  logic [15:0] view_offset,
  input  logic        quit,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  logic [9:0]  rows_reg;
  logic [9:0]  cols_reg;
  logic [15:0] lines_reg;
  logic [1:0]  seq_phase;
  logic [7:0]  lead_byte;
  logic [7:0]  digit_held;
  int unsigned cur_col;
  int unsigned cur_row;
  int unsigned top_line;
  logic        stopped;
  key_result_t expected_keys[$];

  function automatic logic [8:0] letter_key(input logic [7:0] lead, input logic [7:0] b);
    if (lead == BYTE_LBR) begin
      case (b)
        CH_UP:    return KEY_UP;
        CH_DOWN:  return KEY_DOWN;
        CH_RIGHT: return KEY_RIGHT;
        CH_LEFT:  return KEY_LEFT;
        CH_HOME:  return KEY_HOME;
        CH_END:   return KEY_END;
        default:  return KEY_ESC;
      endcase
    end
    if (lead == BYTE_O && b == CH_HOME) return KEY_HOME;
    if (lead == BYTE_O && b == CH_END) return KEY_END;
    return KEY_ESC;
  endfunction

  function automatic logic [8:0] tilde_key(input logic [7:0] d);
    case (d)
      DIGIT_HOME, DIGIT_HOME_ALT: return KEY_HOME;
      DIGIT_DEL:                  return KEY_DEL;
      DIGIT_END, DIGIT_END_ALT:   return KEY_END;
      DIGIT_PGUP:                 return KEY_PGUP;
      DIGIT_PGDN:                 return KEY_PGDN;
      default:                    return KEY_ESC;
    endcase
  endfunction

  task move_and_scroll(input logic [8:0] key);
    int unsigned height;
    case (key)
      KEY_LEFT:  if (cur_col != 0) cur_col--;
      KEY_RIGHT: if (cur_col + 1 < cols_reg) cur_col++;
      KEY_UP:    if (cur_row != 0) cur_row--;
      KEY_DOWN:  if (cur_row < lines_reg) cur_row++;
      KEY_HOME:  cur_col = 0;
      KEY_END:   cur_col = (cols_reg == 0) ? 0 : cols_reg - 1;
      KEY_PGUP:  cur_row = (cur_row >= rows_reg) ? cur_row - rows_reg : 0;
      KEY_PGDN: begin
        if (cur_row < lines_reg)
          cur_row = (cur_row + rows_reg > lines_reg) ? lines_reg : cur_row + rows_reg;
      end
      default: ;
    endcase
    height = (rows_reg == 0) ? 1 : rows_reg;
    if (cur_row < top_line) top_line = cur_row;
    if (cur_row >= top_line + height) top_line = cur_row - height + 1;
  endtask

  task take_item(input logic op, input logic [7:0] b);
    logic [8:0]  key;
    key_result_t r;
    if (stopped) return;
    if (op == OP_TIMEOUT) begin
      if (seq_phase == PH_IDLE) return;
      seq_phase = PH_IDLE;
      key = KEY_ESC;
    end else begin
      case (seq_phase)
        PH_ESC: begin
          lead_byte = b;
          seq_phase = PH_SEQ0;
          return;
        end
        PH_SEQ0: begin
          if (lead_byte == BYTE_LBR && b >= BYTE_0 && b <= BYTE_9) begin
            digit_held = b;
            seq_phase = PH_DIGIT;
            return;
          end
          seq_phase = PH_IDLE;
          key = letter_key(lead_byte, b);
        end
        PH_DIGIT: begin
          seq_phase = PH_IDLE;
          key = (b == BYTE_TILDE) ? tilde_key(digit_held) : KEY_ESC;
        end
        default: begin
          if (b == BYTE_ESC) begin
            seq_phase = PH_ESC;
            return;
          end
          key = {1'b0, b};
        end
      endcase
    end
    r.key = key;
    r.quit = (key == KEY_QUIT);
    if (r.quit) stopped = 1'b1;
    else move_and_scroll(key);
    r.col = cur_col[9:0];
    r.row = cur_row[15:0];
    r.off = top_line[15:0];
    expected_keys.push_back(r);
  endtask

  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (rst) begin
      rows_reg = RESET_SCREEN_ROWS;
      cols_reg = RESET_SCREEN_COLS;
      lines_reg = RESET_LINE_COUNT;
      seq_phase = PH_IDLE;
      lead_byte = '0;
      digit_held = '0;
      cur_col = 0;
      cur_row = 0;
      top_line = 0;
      stopped = 1'b0;
      mismatches = 0;
      expected_keys.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = '{key_code, cursor_col, cursor_row, view_offset, quit};
        if (expected_keys.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: key %0d col %0d row %0d off %0d quit %0d",
                     got.key, got.col, got.row, got.off, got.quit);
        end else begin
          want = expected_keys.pop_front();
          if (got.key !== want.key || got.col !== want.col || got.row !== want.row ||
              got.off !== want.off || got.quit !== want.quit) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected key %0d col %0d row %0d off %0d quit %0d",
                       want.key, want.col, want.row, want.off, want.quit);
              $display("          actual   key %0d col %0d row %0d off %0d quit %0d",
                       got.key, got.col, got.row, got.off, got.quit);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_ROWS: rows_reg = cfg_data[9:0];
          REG_SCREEN_COLS: cols_reg = cfg_data[9:0];
          REG_LINE_COUNT:  lines_reg = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) take_item(operation, in_byte);
    end
    pending = expected_keys.size();
  end

endmodule

>>> tb/testbench.sv
// Testbench top: drives key bytes, timeouts and screen settings, and reports the verdict.
module testbench;
  import kedc_pkg::*;
  import kedc_tb_pkg::*;

  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 218;
  localparam int CALM_PHASE      = 3;
  localparam int WILD_PHASE      = 4;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        operation;
  logic [7:0]  in_byte;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [8:0]  key_code;
  logic [9:0]  cursor_col;
  logic [15:0] cursor_row;
  logic [15:0] view_offset;
  logic        quit;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          mismatches;
  int          pending;

  logic        calm = 1'b0;
  int unsigned items_sent = 0;

  logic [15:0] rows_plan  [RANDOM_PHASES] = '{16'd1, 16'd1023, 16'd0, 16'd10, 16'd0, 16'd3, 16'd24};
  logic [15:0] cols_plan  [RANDOM_PHASES] = '{16'd1, 16'd1023, 16'd0, 16'd20, 16'd0, 16'd7, 16'd80};
  logic [15:0] lines_plan [RANDOM_PHASES] =
    '{16'd0, 16'd65535, 16'd3, 16'd200, 16'd0, 16'd65535, 16'd0};
  logic [7:0]  csi_letters [6] = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_HOME, CH_END};

  key_escape_decode_and_cursor dut (.*);
  key_decode_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) result_stall <= !calm && ($urandom_range(0, 99) < 14);

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_CTRL_Q || b == BYTE_ESC);
    return b;
  endfunction

  task send_item(input logic op, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 14) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    in_byte <= b;
    do @(posedge clk); while (item_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task send_byte(input logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task send_timeout();
    send_item(OP_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  task send_escape_seq(input logic [7:0] lead, input logic [7:0] tail);
    send_byte(BYTE_ESC);
    send_byte(lead);
    send_byte(tail);
  endtask

  task send_tilde_seq(input logic [7:0] digit);
    send_escape_seq(BYTE_LBR, digit);
    send_byte(BYTE_TILDE);
  endtask

  task write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task set_screen(input logic [15:0] rows, input logic [15:0] cols, input logic [15:0] lines);
    write_reg(REG_SCREEN_ROWS, rows);
    write_reg(REG_SCREEN_COLS, cols);
    write_reg(REG_LINE_COUNT, lines);
    cfg_valid <= 1'b0;
  endtask

  task settle();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task random_group();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_escape_seq(BYTE_LBR, csi_letters[3'($urandom_range(0, 5))]);
    end else if (pick < 58) begin
      send_tilde_seq(8'(BYTE_0 + $urandom_range(0, 9)));
    end else if (pick < 64) begin
      if ($urandom_range(0, 3) == 0) send_escape_seq(BYTE_O, plain_byte());
      else send_escape_seq(BYTE_O, $urandom_range(0, 1) ? CH_HOME : CH_END);
    end else if (pick < 80) begin
      send_byte(plain_byte());
    end else if (pick < 87) begin
      send_escape_seq(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_timeout();
    end else if (pick < 93) begin
      send_escape_seq(BYTE_LBR, 8'(BYTE_0 + $urandom_range(0, 9)));
      send_byte($urandom_range(0, 1) ? BYTE_TILDE : 8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      send_escape_seq(BYTE_ESC, 8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0: send_timeout();
        1: begin
          send_byte(BYTE_ESC);
          send_timeout();
        end
        default: begin
          send_byte(BYTE_ESC);
          send_byte(BYTE_LBR);
          send_timeout();
        end
      endcase
    end
  endtask

  initial begin
    int unsigned target;
    rst = 1'b1;
    item_valid = 1'b0;
    operation = OP_BYTE;
    in_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SCREEN_ROWS;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_timeout();
    settle();
    set_screen(16'd4, 16'd6, 16'd50);
    send_escape_seq(BYTE_LBR, CH_DOWN);
    send_tilde_seq(DIGIT_PGDN);
    send_tilde_seq(DIGIT_PGUP);
    send_escape_seq(BYTE_O, CH_END);
    send_escape_seq(BYTE_LBR, CH_RIGHT);
    send_tilde_seq(BYTE_9);
    send_byte(BYTE_ESC);
    send_timeout();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == WILD_PHASE) begin
        write_reg(REG_SCREEN_ROWS, 16'($urandom_range(0, 65535)));
        write_reg(REG_SCREEN_COLS, 16'($urandom_range(0, 65535)));
        write_reg(REG_LINE_COUNT, 16'($urandom_range(0, 3000)));
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
      end else begin
        set_screen(rows_plan[p], cols_plan[p], lines_plan[p]);
      end
      calm = (p == CALM_PHASE);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_group();
    end
    calm = 1'b0;

    send_timeout();
    send_byte(BYTE_CTRL_Q);
    send_escape_seq(BYTE_LBR, CH_UP);
    send_byte(plain_byte());
    send_timeout();
    item_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
